/* src/ttuv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ttuv_pkg;
    localparam int POS_WIDTH_DEF = 32;
    localparam int UV_WIDTH_DEF  = 16;
    localparam int TAN_WIDTH     = 18;
endpackage
`default_nettype wire

/* src/ttuv_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module ttuv_front #(
    parameter int POS_WIDTH = ttuv_pkg::POS_WIDTH_DEF,
    parameter int UV_WIDTH  = ttuv_pkg::UV_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [POS_WIDTH-1:0] px,
    input  wire logic [POS_WIDTH-1:0] py,
    input  wire logic [POS_WIDTH-1:0] pz,
    input  wire logic [UV_WIDTH-1:0]  tu,
    input  wire logic [UV_WIDTH-1:0]  tv,
    input  wire logic                 lm,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output logic [POS_WIDTH*3-1:0]    q_p0,
    output logic [POS_WIDTH*3-1:0]    q_p1,
    output logic [POS_WIDTH*3-1:0]    q_p2,
    output logic [UV_WIDTH*2-1:0]     q_t0,
    output logic [UV_WIDTH*2-1:0]     q_t1,
    output logic [UV_WIDTH*2-1:0]     q_t2
);
    localparam int QD = 2;
    logic [1:0] phase_reg;
    logic [POS_WIDTH*3-1:0] h0_reg, h1_reg;
    logic [UV_WIDTH*2-1:0]  g0_reg, g1_reg;
    logic [POS_WIDTH*3-1:0] qp0_reg [QD], qp1_reg [QD], qp2_reg [QD];
    logic [UV_WIDTH*2-1:0]  qt0_reg [QD], qt1_reg [QD], qt2_reg [QD];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic acc, push, pop;

    assign in_ready = (phase_reg != 2'd2) || (cnt_reg != 2'(QD));
    assign acc = in_valid && in_ready;
    assign push = acc && (phase_reg == 2'd2);
    assign q_valid = cnt_reg != 2'd0;
    assign pop = q_valid && q_ready;
    assign q_p0 = qp0_reg[rp_reg];
    assign q_p1 = qp1_reg[rp_reg];
    assign q_p2 = qp2_reg[rp_reg];
    assign q_t0 = qt0_reg[rp_reg];
    assign q_t1 = qt1_reg[rp_reg];
    assign q_t2 = qt2_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
            h0_reg <= '0;
            h1_reg <= '0;
            g0_reg <= '0;
            g1_reg <= '0;
        end
        else
        begin
            if (acc)
            begin
                if (phase_reg == 2'd2)
                    phase_reg <= 2'd0;
                else
                begin
                    if (phase_reg == 2'd0)
                    begin
                        h0_reg <= {pz, py, px};
                        g0_reg <= {tv, tu};
                    end
                    else
                    begin
                        h1_reg <= {pz, py, px};
                        g1_reg <= {tv, tu};
                    end
                    phase_reg <= lm ? 2'd0 : phase_reg + 2'd1;
                end
            end
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qp0_reg[wp_reg] <= h0_reg;
            qp1_reg[wp_reg] <= h1_reg;
            qp2_reg[wp_reg] <= {pz, py, px};
            qt0_reg[wp_reg] <= g0_reg;
            qt1_reg[wp_reg] <= g1_reg;
            qt2_reg[wp_reg] <= {tv, tu};
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QD))
        else $error("queue overflow");
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("push lost");
    a_ph: assert property (@(posedge clk) disable iff (!rst_n) phase_reg != 2'd3)
        else $error("bad phase");
endmodule
`default_nettype wire

/* src/ttuv_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module ttuv_back #(
    parameter int POS_WIDTH = ttuv_pkg::POS_WIDTH_DEF,
    parameter int UV_WIDTH  = ttuv_pkg::UV_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    input  wire logic [POS_WIDTH*3-1:0]     q_p0,
    input  wire logic [POS_WIDTH*3-1:0]     q_p1,
    input  wire logic [POS_WIDTH*3-1:0]     q_p2,
    input  wire logic [UV_WIDTH*2-1:0]      q_t0,
    input  wire logic [UV_WIDTH*2-1:0]      q_t1,
    input  wire logic [UV_WIDTH*2-1:0]      q_t2,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [ttuv_pkg::TAN_WIDTH-1:0]  tx,
    output logic [ttuv_pkg::TAN_WIDTH-1:0]  ty,
    output logic [ttuv_pkg::TAN_WIDTH-1:0]  tz,
    output logic                            dg,
    output logic                            lt
);
    localparam int DW = POS_WIDTH + 1;   // position delta
    localparam int UW = UV_WIDTH + 1;    // uv delta
    localparam int PW = DW + UW;         // product
    localparam int TW = PW + 1;          // raw tangent magnitude
    localparam int XW = 2 * UW;          // uv product
    localparam int BW = $clog2(TW + 1);
    localparam int TNW = ttuv_pkg::TAN_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_NORM = 7'b0000100,
        S_SQ   = 7'b0001000,
        S_SQRT = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t st_reg;
    logic signed [DW-1:0] e1_reg [3], e2_reg [3];
    logic signed [UW-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [TW-1:0] t_reg [3];
    logic [TW-1:0] mag_reg [3];
    logic neg_reg [3];
    logic [29:0] a_reg [3];
    logic [61:0] s_reg;
    logic [61:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  it_reg;
    logic [1:0]  ci_reg;
    logic [5:0]  dit_reg;
    logic [48:0] num_reg;
    logic [32:0] drem_reg;
    logic [17:0] quo_reg;
    logic [TNW-1:0] res_reg [3];
    logic degen_reg;
    logic [1:0] k_reg;
    logic [BW-1:0] b_reg;

    assign q_ready = st_reg == S_IDLE;
    assign out_valid = st_reg == S_OUT;
    assign tx = res_reg[0];
    assign ty = res_reg[1];
    assign tz = res_reg[2];
    assign dg = degen_reg;
    assign lt = k_reg == 2'd2;

    function automatic logic signed [DW-1:0] pc(input logic [POS_WIDTH*3-1:0] v, input int i);
        return DW'($signed(v[i*POS_WIDTH +: POS_WIDTH]));
    endfunction

    function automatic logic signed [UW-1:0] uc(input logic [UV_WIDTH*2-1:0] v, input int i);
        return UW'($signed(v[i*UV_WIDTH +: UV_WIDTH]));
    endfunction

    logic signed [XW-1:0] xp_a, xp_b;
    logic signed [XW:0] uv_cross;
    logic signed [DW-1:0] e1_sel, e2_sel;
    logic signed [PW-1:0] tp_a, tp_b;
    logic [BW-1:0] bl;
    logic [TW-1:0] mmax;
    logic [2*30+1:0] sqsum;
    logic [33:0] dtrial;
    logic dbit;
    logic [17:0] qfull;
    logic [18:0] qround;
    always_comb
    begin
        xp_a = XW'(du2_reg) * XW'(dv1_reg);
        xp_b = XW'(dv2_reg) * XW'(du1_reg);
        uv_cross = (XW+1)'(xp_a) - (XW+1)'(xp_b);
        e1_sel = e1_reg[ci_reg];
        e2_sel = e2_reg[ci_reg];
        tp_a = PW'(e2_sel) * PW'(dv1_reg);
        tp_b = PW'(e1_sel) * PW'(dv2_reg);
        mmax = mag_reg[0] | mag_reg[1] | mag_reg[2];
        bl = '0;
        for (int j = 0; j < TW; j++)
            if (mmax[j])
                bl = BW'(j + 1);
        sqsum = 62'(a_reg[0]) * 62'(a_reg[0]) + 62'(a_reg[1]) * 62'(a_reg[1])
              + 62'(a_reg[2]) * 62'(a_reg[2]);
        dtrial = {drem_reg, num_reg[48]};
        dbit = dtrial >= {2'b00, root_reg};
        qfull = {quo_reg[16:0], dbit};
        qround = ({1'b0, qfull} + 19'd1) >> 1;
    end

    logic [61:0] remw;
    logic [63:0] cand;
    always_comb
    begin
        remw = {rem_reg[59:0], s_reg[61:60]};
        cand = {32'd0, root_reg[29:0], 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            k_reg <= 2'd0;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                    if (q_valid)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            e1_reg[i] <= pc(q_p1, i) - pc(q_p0, i);
                            e2_reg[i] <= pc(q_p2, i) - pc(q_p0, i);
                        end
                        du1_reg <= uc(q_t1, 0) - uc(q_t0, 0);
                        dv1_reg <= uc(q_t1, 1) - uc(q_t0, 1);
                        du2_reg <= uc(q_t2, 0) - uc(q_t0, 0);
                        dv2_reg <= uc(q_t2, 1) - uc(q_t0, 1);
                        ci_reg <= 2'd0;
                        st_reg <= S_MUL;
                    end
                S_MUL:
                begin
                    // one component per cycle
                    t_reg[ci_reg] <= TW'(tp_a) - TW'(tp_b);
                    if (ci_reg == 2'd2)
                        st_reg <= S_NORM;
                    ci_reg <= ci_reg + 2'd1;
                end
                S_NORM:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= (t_reg[i] < 0) ^ (uv_cross < 0);
                        mag_reg[i] <= t_reg[i] < 0 ? TW'(-t_reg[i]) : t_reg[i];
                    end
                    st_reg <= S_SQ;
                    ci_reg <= 2'd0;
                end
                S_SQ:
                begin
                    if (ci_reg == 2'd0)
                    begin
                        b_reg <= bl;
                        for (int i = 0; i < 3; i++)
                            a_reg[i] <= (bl <= BW'(30))
                                ? 30'(mag_reg[i] << (BW'(30) - bl))
                                : 30'(mag_reg[i] >> (bl - BW'(30)));
                        ci_reg <= 2'd1;
                    end
                    else
                    begin
                        degen_reg <= b_reg == '0;
                        s_reg <= sqsum;
                        rem_reg <= '0;
                        root_reg <= '0;
                        it_reg <= '0;
                        st_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    // restoring square root, one result bit per cycle
                    if (64'(remw) >= cand)
                    begin
                        rem_reg <= 62'(64'(remw) - cand);
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= remw;
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    s_reg <= {s_reg[59:0], 2'b00};
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == 5'd30)
                    begin
                        ci_reg <= 2'd0;
                        st_reg <= degen_reg ? S_OUT : S_DIV;
                        dit_reg <= '0;
                        num_reg <= {2'b0, a_reg[0], 17'd0};
                        drem_reg <= '0;
                        if (degen_reg)
                        begin
                            for (int i = 0; i < 3; i++)
                                res_reg[i] <= '0;
                            k_reg <= 2'd0;
                        end
                    end
                end
                S_DIV:
                begin
                    // restoring divide of a << 17 by the root
                    quo_reg <= qfull;
                    if (dit_reg == 6'd48)
                    begin
                        dit_reg <= '0;
                        res_reg[ci_reg] <= neg_reg[ci_reg] ? TNW'(19'd0 - qround)
                                                           : TNW'(qround);
                        drem_reg <= '0;
                        ci_reg <= ci_reg + 2'd1;
                        num_reg <= {2'b0, a_reg[ci_reg == 2'd2 ? 2'd2 : ci_reg + 2'd1],
                                    17'd0};
                        if (ci_reg == 2'd2)
                        begin
                            st_reg <= S_OUT;
                            k_reg <= 2'd0;
                        end
                    end
                    else
                    begin
                        if (dbit)
                            drem_reg <= 33'(dtrial - {2'b00, root_reg});
                        else
                            drem_reg <= 33'(dtrial);
                        num_reg <= {num_reg[47:0], 1'b0};
                        dit_reg <= dit_reg + 6'd1;
                    end
                end
                S_OUT:
                    if (out_ready)
                    begin
                        if (k_reg == 2'd2)
                        begin
                            k_reg <= 2'd0;
                            st_reg <= S_IDLE;
                        end
                        else
                            k_reg <= k_reg + 2'd1;
                    end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    a_oh: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_reg))
        else $error("state not one-hot");
    a_dg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dg |-> tx == '0 && ty == '0 && tz == '0)
        else $error("degenerate nonzero");
    a_k: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && lt |=> st_reg == S_IDLE)
        else $error("run end");
endmodule
`default_nettype wire

/* src/triangle_tangent_from_uv.sv */
// The back end takes a triangle only when idle; its three results then follow one per cycle
// while out_ready is high. The front always accepts the first and second vertices of a triangle;
// a triangle holds the back end through a 31-step square root and three 49-step divides (a
// degenerate triangle skips the divides), and no new triangle enters until its results are taken.
// A two-entry triangle queue lets the front keep accepting while the back works.
// Reset (rst_n, async, active low) clears vertex phase, queue and back-end state.
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_from_uv #(
    parameter int POS_WIDTH = ttuv_pkg::POS_WIDTH_DEF,
    parameter int UV_WIDTH  = ttuv_pkg::UV_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [POS_WIDTH-1:0]       pos_x,
    input  wire logic [POS_WIDTH-1:0]       pos_y,
    input  wire logic [POS_WIDTH-1:0]       pos_z,
    input  wire logic [UV_WIDTH-1:0]        tex_u,
    input  wire logic [UV_WIDTH-1:0]        tex_v,
    input  wire logic                       last_of_mesh,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [ttuv_pkg::TAN_WIDTH-1:0]  tangent_x,
    output logic [ttuv_pkg::TAN_WIDTH-1:0]  tangent_y,
    output logic [ttuv_pkg::TAN_WIDTH-1:0]  tangent_z,
    output logic                            degenerate,
    output logic                            last_of_triangle
);
    logic qv, qr;
    logic [POS_WIDTH*3-1:0] p0, p1, p2;
    logic [UV_WIDTH*2-1:0] t0, t1, t2;

    ttuv_front #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .px(pos_x), .py(pos_y), .pz(pos_z), .tu(tex_u), .tv(tex_v), .lm(last_of_mesh),
        .q_valid(qv), .q_ready(qr), .q_p0(p0), .q_p1(p1), .q_p2(p2),
        .q_t0(t0), .q_t1(t1), .q_t2(t2)
    );

    ttuv_back #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(qv), .q_ready(qr),
        .q_p0(p0), .q_p1(p1), .q_p2(p2), .q_t0(t0), .q_t1(t1), .q_t2(t2),
        .out_valid(out_valid), .out_ready(out_ready),
        .tx(tangent_x), .ty(tangent_y), .tz(tangent_z),
        .dg(degenerate), .lt(last_of_triangle)
    );
endmodule
`default_nettype wire
